>>> design/fdl_pkg.sv
package fdl_pkg;

   // Default build values for the top-level parameters.
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_SIZE_CLAMP  = 256;
   localparam int DEF_NAME_BYTES  = 56;

   // The target name registers always cover this many bytes.
   localparam int TARGET_BYTES = 56;
   localparam int LEN_W        = 6;
   // Size, selector and reserved bytes ahead of the name field.
   localparam int HDR_BYTES    = 8;
   // Byte position inside an entry (at most HDR_BYTES + TARGET_BYTES bytes).
   localparam int POS_W        = 6;

   // Directory signature, first byte first: 'Q' 'E' 'M' 'U'.
   localparam logic [7:0] SIG_CHARS [4] = '{8'h51, 8'h45, 8'h4D, 8'h55};

   typedef enum logic [2:0] {
      CSR_NAME_0 = 3'd0,
      CSR_NAME_1 = 3'd1,
      CSR_NAME_2 = 3'd2,
      CSR_NAME_3 = 3'd3,
      CSR_NAME_4 = 3'd4,
      CSR_NAME_5 = 3'd5,
      CSR_NAME_6 = 3'd6,
      CSR_LENGTH = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TARGET_BYTES-1:0][7:0] name_bytes;
      logic [LEN_W-1:0]             length;
   } cfg_type;

   typedef struct packed {
      logic        signature_ok;
      logic        found;
      logic [15:0] selector;
      logic [8:0]  file_size;
   } rsp_type;

endpackage

>>> design/fdl_if.sv
interface fdl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface fdl_rsp_if;
   logic        valid;
   logic        ready;
   logic        signature_ok;
   logic        found;
   logic [15:0] selector;
   logic [8:0]  file_size;

   modport source (output valid, output signature_ok, output found, output selector,
                    output file_size, input ready);
   modport sink   (input valid, input signature_ok, input found, input selector,
                   input file_size, output ready);
endinterface

interface fdl_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/fdl_csr.sv
module fdl_csr (
   input  logic              clock,
   input  logic              reset,
   fdl_csr_if.sink           csr_bus,
   output fdl_pkg::cfg_type  cfg
);

   logic [63:0]                 name_ff [7];
   logic [fdl_pkg::LEN_W-1:0]   length_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 7; k++) begin
            name_ff[k] <= '0;
         end
         length_ff <= '0;
      end else if (csr_bus.valid) begin
         case (fdl_pkg::csr_index_type'(csr_bus.index))
            fdl_pkg::CSR_NAME_0: name_ff[0] <= csr_bus.data;
            fdl_pkg::CSR_NAME_1: name_ff[1] <= csr_bus.data;
            fdl_pkg::CSR_NAME_2: name_ff[2] <= csr_bus.data;
            fdl_pkg::CSR_NAME_3: name_ff[3] <= csr_bus.data;
            fdl_pkg::CSR_NAME_4: name_ff[4] <= csr_bus.data;
            fdl_pkg::CSR_NAME_5: name_ff[5] <= csr_bus.data;
            fdl_pkg::CSR_NAME_6: name_ff[6] <= csr_bus.data;
            fdl_pkg::CSR_LENGTH: length_ff  <= csr_bus.data[fdl_pkg::LEN_W-1:0];
            default:             length_ff  <= length_ff;
         endcase
      end
   end

   // Unpack the name registers into bytes, first byte in the low bits.
   always_comb begin
      for (int i = 0; i < fdl_pkg::TARGET_BYTES; i++) begin
         cfg.name_bytes[i] = name_ff[i / 8][(i % 8) * 8 +: 8];
      end
      cfg.length = length_ff;
   end

endmodule

>>> design/fdl_scan.sv
module fdl_scan #(
   parameter int MAX_ENTRIES = fdl_pkg::DEF_MAX_ENTRIES,
   parameter int SIZE_CLAMP  = fdl_pkg::DEF_SIZE_CLAMP,
   parameter int NAME_BYTES  = fdl_pkg::DEF_NAME_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              start_req,
   input  fdl_pkg::cfg_type  cfg,
   output logic              emit,
   output fdl_pkg::rsp_type  rsp
);

   localparam int ENTRY_BYTES = fdl_pkg::HDR_BYTES + NAME_BYTES;
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CLAMP_W     = $clog2(SIZE_CLAMP + 1);
   localparam int POS_W       = fdl_pkg::POS_W;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_SIG     = 4'b0010,
      PH_COUNT   = 4'b0100,
      PH_ENTRIES = 4'b1000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [COUNT_W-1:0]    left_ff, left_in;
   logic                  good_ff, good_in;
   logic [23:0]           shift_ff, shift_in;
   logic [CLAMP_W-1:0]    esize_ff, esize_in;
   logic [15:0]           esel_ff, esel_in;
   logic                  match_ff, match_in;
   logic [15:0]           ksel_ff, ksel_in;
   logic [CLAMP_W-1:0]    ksize_ff, ksize_in;

   always_comb begin
      phase_type            phase_cur;
      logic [POS_W-1:0]     pos_cur;
      logic [POS_W-1:0]     name_idx;
      logic [31:0]          word;
      logic [COUNT_W-1:0]   count;
      logic                 match_cur;
      logic                 hit;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      good_in  = good_ff;
      shift_in = shift_ff;
      esize_in = esize_ff;
      esel_in  = esel_ff;
      match_in = match_ff;
      ksel_in  = ksel_ff;
      ksize_in = ksize_ff;
      emit     = 1'b0;

      phase_cur = phase_ff;
      pos_cur   = pos_ff;
      word      = {shift_ff, data_byte};
      name_idx  = pos_ff - POS_W'(fdl_pkg::HDR_BYTES);
      count     = '0;
      match_cur = match_ff;

      // Restart the scan from any phase.
      if (start_req) begin
         phase_cur = PH_SIG;
         pos_cur   = '0;
         good_in   = 1'b1;
         left_in   = '0;
         ksel_in   = '0;
         ksize_in  = '0;
      end

      if (accept) begin
         case (phase_cur)
            PH_SIG: begin
               if (data_byte != fdl_pkg::SIG_CHARS[pos_cur[1:0]]) begin
                  good_in = 1'b0;
               end
               pos_in   = POS_W'(pos_cur + 1'b1);
               phase_in = PH_SIG;
               if (pos_cur == POS_W'(3)) begin
                  pos_in = '0;
                  if (good_in) begin
                     phase_in = PH_COUNT;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
            PH_COUNT: begin
               shift_in = {shift_ff[15:0], data_byte};
               pos_in   = POS_W'(pos_cur + 1'b1);
               if (pos_cur == POS_W'(3)) begin
                  count   = (word > 32'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
                                                      : word[COUNT_W-1:0];
                  left_in = count;
                  pos_in  = '0;
                  if (count == '0) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PH_ENTRIES;
                  end
               end
            end
            PH_ENTRIES: begin
               if (pos_cur == '0) begin
                  match_cur = (cfg.length <= fdl_pkg::LEN_W'(NAME_BYTES));
               end
               match_in = match_cur;
               if (pos_cur < POS_W'(3)) begin
                  shift_in = {shift_ff[15:0], data_byte};
               end else if (pos_cur == POS_W'(3)) begin
                  // Saturate the size as soon as it is complete.
                  esize_in = (word > 32'(SIZE_CLAMP)) ? CLAMP_W'(SIZE_CLAMP)
                                                      : word[CLAMP_W-1:0];
               end else if (pos_cur < POS_W'(6)) begin
                  esel_in = {esel_ff[7:0], data_byte};
               end else if (pos_cur >= POS_W'(fdl_pkg::HDR_BYTES)) begin
                  if (name_idx < cfg.length) begin
                     if (data_byte != cfg.name_bytes[name_idx]) begin
                        match_in = 1'b0;
                     end
                  end else if (name_idx == cfg.length) begin
                     if (data_byte != 8'h00) begin
                        match_in = 1'b0;
                     end
                  end
               end
               pos_in = POS_W'(pos_cur + 1'b1);
               if (pos_cur == POS_W'(ENTRY_BYTES - 1)) begin
                  pos_in = '0;
                  // First named entry with a live selector wins.
                  if (ksel_ff == '0 && match_in && esel_ff != '0) begin
                     ksel_in  = esel_ff;
                     ksize_in = esize_ff;
                  end
                  if (left_ff != '0) begin
                     left_in = left_ff - 1'b1;
                  end
                  if (left_ff <= COUNT_W'(1)) begin
                     emit = 1'b1;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (emit) begin
            phase_in = PH_IDLE;
            pos_in   = '0;
         end
      end else begin
         good_in  = good_ff;
         left_in  = left_ff;
         ksel_in  = ksel_ff;
         ksize_in = ksize_ff;
      end

      hit              = good_in && (ksel_in != '0);
      rsp.signature_ok = good_in;
      rsp.found        = hit;
      rsp.selector     = hit ? ksel_in : '0;
      rsp.file_size    = hit ? 9'(ksize_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         left_ff  <= '0;
         good_ff  <= 1'b0;
         ksel_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         good_ff  <= good_in;
         ksel_ff  <= ksel_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      esize_ff <= esize_in;
      esel_ff  <= esel_in;
      match_ff <= match_in;
      ksize_ff <= ksize_in;
   end

endmodule

>>> design/fdl_rsp_queue.sv
module fdl_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fdl_pkg::rsp_type  push_data,
   input  logic              pop_ready,
   output logic              full,
   output logic              out_valid,
   output fdl_pkg::rsp_type  out_data
);

   fdl_pkg::rsp_type  slot_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic              pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/file_directory_lookup.sv
// Directory lookup: one stream byte per request, one request per cycle unless stalled.
// The request that ends a scan registers its result into the queue, behind any older result.
// A two-deep result queue decouples the sides; requests stall only when it holds two results.
// Reset (synchronous, active high) idles the scan, clears the target name and length,
// and empties the result queue.
module file_directory_lookup #(
   parameter int MAX_ENTRIES = fdl_pkg::DEF_MAX_ENTRIES,
   parameter int SIZE_CLAMP  = fdl_pkg::DEF_SIZE_CLAMP,
   parameter int NAME_BYTES  = fdl_pkg::DEF_NAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   fdl_req_if.sink     req_bus,
   fdl_rsp_if.source   rsp_bus,
   fdl_csr_if.sink     csr_bus
);

   fdl_pkg::cfg_type  cfg;
   fdl_pkg::rsp_type  scan_rsp;
   fdl_pkg::rsp_type  out_rsp;
   logic              scan_emit;
   logic              queue_full;
   logic              req_accept;

   // Target name and length registers; writes are always taken.
   fdl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Hold off requests only while both result slots are occupied, so every
   // accepted request that finishes a scan has room for its result.
   assign req_bus.ready = !queue_full;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // Scan state: signature check, count capture, per-entry name compare.
   fdl_scan #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SIZE_CLAMP  (SIZE_CLAMP),
      .NAME_BYTES  (NAME_BYTES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_bus.data_byte),
      .start_req (req_bus.start_req),
      .cfg       (cfg),
      .emit      (scan_emit),
      .rsp       (scan_rsp)
   );

   // Result register pair; drain in order.
   fdl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_emit),
      .push_data (scan_rsp),
      .pop_ready (rsp_bus.ready),
      .full      (queue_full),
      .out_valid (rsp_bus.valid),
      .out_data  (out_rsp)
   );

   assign rsp_bus.signature_ok = out_rsp.signature_ok;
   assign rsp_bus.found        = out_rsp.found;
   assign rsp_bus.selector     = out_rsp.selector;
   assign rsp_bus.file_size    = out_rsp.file_size;

`ifndef ASSERT_OFF
   // A result is only produced by an accepted request.
   a_emit_needs_accept: assert property (@(posedge clock) disable iff (reset)
      scan_emit |-> req_accept)
      else $error("result produced without an accepted request");

   // A hit requires a good signature and a live selector.
   a_found_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.found) |-> (rsp_bus.signature_ok && rsp_bus.selector != '0))
      else $error("found result without signature or selector");

   // A miss carries no selector or size.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.selector == '0 && rsp_bus.file_size == '0))
      else $error("miss result carries selector or size");

   // The queue comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");
`endif

endmodule
